@@ hw/rtl/lpse_pkg.sv @@
// ----------------------------------------------------------------------------
// LED pixel stream encoder package
// Shared constants, record and state types for the pixel stream encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

   // Pixel formats.
   localparam logic [1:0] FMT_RAW       = 2'd0;
   localparam logic [1:0] FMT_CLOCKED   = 2'd1;
   localparam logic [1:0] FMT_ONEWIRE   = 2'd2;
   localparam logic [1:0] FMT_ONEWIRE_W = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_PIXEL_FORMAT      = 2'd0;
   localparam logic [1:0] REG_DITHER_ENABLE     = 2'd1;
   localparam logic [1:0] REG_COLOR_ORDER       = 2'd2;
   localparam logic [1:0] REG_GLOBAL_BRIGHTNESS = 2'd3;

   // Color orders.
   localparam logic [2:0] ORD_RGB = 3'd0;
   localparam logic [2:0] ORD_RBG = 3'd1;
   localparam logic [2:0] ORD_GRB = 3'd2;
   localparam logic [2:0] ORD_BGR = 3'd3;
   localparam logic [2:0] ORD_BRG = 3'd4;
   localparam logic [2:0] ORD_GBR = 3'd5;

   // Byte constants.
   localparam logic [7:0] HEADER_MARK  = 8'hE0;
   localparam logic [7:0] TRAILER_BYTE = 8'hFF;
   localparam logic [7:0] START_BYTE   = 8'h00;
   localparam logic [7:0] CHANNEL_MAX  = 8'hFF;
   localparam logic [1:0] FRACTION_MASK = 2'h3;

   // Run lengths.
   localparam int START_LEN   = 4;
   localparam int TRAILER_LEN = 19;
   localparam int CNT_W       = 5;
   localparam int DATA_BYTES  = 12;
   localparam int DATA_W      = DATA_BYTES * 8;

   localparam logic [3:0] LEN_BYTES   = 4'd3;
   localparam logic [3:0] LEN_ONEWIRE = 4'd9;
   localparam logic [3:0] LEN_ONEW_W  = 4'd12;

   // One pixel, ready to be serialized.
   typedef struct packed {
      logic              clocked;
      logic              first;
      logic              last;
      logic [7:0]        head_byte;
      logic [3:0]        data_len;
      logic [DATA_W-1:0] data;
   } pixel_rec_type;

   // Serializer states.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_HEAD  = 5'b00100,
      ST_DATA  = 5'b01000,
      ST_TRAIL = 5'b10000
   } ser_state_type;

endpackage

@@ hw/rtl/lpse_if.sv @@
// ----------------------------------------------------------------------------
// LED pixel stream encoder channels
// Valid/ready interfaces for pixel items, byte items and register writes.
// ----------------------------------------------------------------------------

// Pixel input channel.
interface lpse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] extra;
   logic       first_pixel;
   logic       last_pixel;

   modport source (output valid, red, green, blue, extra, first_pixel, last_pixel,
                   input ready);
   modport sink   (input valid, red, green, blue, extra, first_pixel, last_pixel,
                   output ready);
endinterface

// Byte output channel.
interface lpse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// Register write channel.
interface lpse_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/lpse_lane.sv @@
// ----------------------------------------------------------------------------
// LED pixel stream encoder lane
// Dithers one channel value and encodes it as a one-wire 24-bit pattern.
// ----------------------------------------------------------------------------
module lpse_lane (
   input  logic [7:0]  value,
   input  logic [1:0]  frac,
   input  logic        dither_on,
   input  logic [1:0]  phase,
   output logic [7:0]  enc_byte,
   output logic [23:0] enc_word
);
   import lpse_pkg::*;

   // Raise the value by one when its fraction exceeds the phase.
   always_comb begin
      if (dither_on && (value != CHANNEL_MAX) && ((frac & FRACTION_MASK) > phase)) begin
         enc_byte = value + 8'd1;
      end else begin
         enc_byte = value;
      end
   end

   // Each data bit becomes three line bits, MSB first: one is 110, zero is 100.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         enc_word[3*i +: 3] = enc_byte[i] ? 3'b110 : 3'b100;
      end
   end

endmodule

@@ hw/rtl/lpse_serializer.sv @@
// ----------------------------------------------------------------------------
// LED pixel stream encoder serializer
// Walks one pixel record and sends its bytes through a registered output.
// ----------------------------------------------------------------------------
module lpse_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rec_valid,
   input  lpse_pkg::pixel_rec_type rec,
   output logic                   rec_ready,
   lpse_rsp_if.source             rsp_chan
);
   import lpse_pkg::*;

   ser_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [7:0]          head_ff, head_in;
   logic [3:0]          len_ff, len_in;
   logic                trail_ff, trail_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic                adv;
   logic                final_byte;
   logic                load;

   // Output register is free when empty or being taken.
   assign adv = !out_valid_ff || rsp_chan.ready;

   // The byte that closes the current run.
   assign final_byte = adv && (cnt_ff == '0) &&
                       (((state_ff == ST_DATA) && !trail_ff) || (state_ff == ST_TRAIL));

   assign rec_ready = (state_ff == ST_IDLE) || final_byte;
   assign load      = rec_valid && rec_ready;

   // Byte sequencing.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      head_in      = head_ff;
      len_in       = len_ff;
      trail_in     = trail_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_START: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_byte_in  = START_BYTE;
               out_last_in  = 1'b0;
               if (cnt_ff == '0) begin
                  state_in = ST_HEAD;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         ST_HEAD: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_byte_in  = head_ff;
               out_last_in  = 1'b0;
               state_in     = ST_DATA;
               cnt_in       = CNT_W'(len_ff) - 1'b1;
            end
         end
         ST_DATA: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_byte_in  = data_ff[DATA_W-1 -: 8];
               data_in      = {data_ff[DATA_W-9:0], 8'h00};
               out_last_in  = 1'b0;
               if (cnt_ff == '0) begin
                  if (trail_ff) begin
                     state_in = ST_TRAIL;
                     cnt_in   = CNT_W'(TRAILER_LEN - 1);
                  end else begin
                     out_last_in = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         ST_TRAIL: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_byte_in  = TRAILER_BYTE;
               out_last_in  = 1'b0;
               if (cnt_ff == '0) begin
                  out_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Take the next pixel record while idle or as the current run ends.
      if (load) begin
         data_in  = rec.data;
         head_in  = rec.head_byte;
         len_in   = rec.data_len;
         trail_in = rec.clocked && rec.last;
         if (rec.clocked && rec.first) begin
            state_in = ST_START;
            cnt_in   = CNT_W'(START_LEN - 1);
         end else if (rec.clocked) begin
            state_in = ST_HEAD;
         end else begin
            state_in = ST_DATA;
            cnt_in   = CNT_W'(rec.data_len) - 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      data_ff     <= data_in;
      head_ff     <= head_in;
      len_ff      <= len_in;
      trail_ff    <= trail_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.last_of_run = out_last_ff;

endmodule

@@ hw/rtl/led_pixel_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// LED pixel stream encoder
// Turns pixel items into the byte stream shifted out to an LED strip.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one pixel item (red, green, blue, extra, frame marks).
//   rsp_chan gives the bytes for that pixel, last_of_run set on the final one.
//   csr_chan writes the format, dither enable, color order and brightness;
//   it is always ready and should be written only while the block is idle.
// Path: an accepted item is held in the stage register, then loaded into the
//   serializer, whose output register gives the first byte of the pixel.
// Throughput: one byte per cycle on rsp_chan while rsp_chan is ready. Bytes
//   per pixel: 3 raw, 4 to 27 clocked, 9 one-wire RGB, 12 one-wire RGBW.
//   The byte serializer sets the rate; four channel lanes dither and encode
//   a pixel in the cycle it is accepted, and one pixel waits in a stage
//   register while the previous one is sent.
// Reset: registers return to their defaults (brightness 31), the dither phase
//   clears and any pending item is dropped.
// Stall: when rsp_chan is not ready the output byte holds, and req_chan stays
//   ready until the stage register holds a waiting pixel.
// ----------------------------------------------------------------------------
module led_pixel_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   lpse_req_if.sink   req_chan,
   lpse_rsp_if.source rsp_chan,
   lpse_csr_if.sink   csr_chan
);
   import lpse_pkg::*;

   logic [1:0]    pixel_format_ff;
   logic          dither_enable_ff;
   logic [2:0]    color_order_ff;
   logic [4:0]    global_brightness_ff;
   logic [1:0]    phase_ff, phase_in;
   logic          accept;
   logic          dither_on;
   logic [7:0]    lane_value [4];
   logic [1:0]    lane_frac  [4];
   logic [7:0]    lane_byte  [4];
   logic [23:0]   lane_word  [4];
   logic [1:0]    sel [3];
   logic          onewire;
   pixel_rec_type rec_in, stage_ff;
   logic          stage_valid_ff, stage_valid_in;
   logic          rec_ready;

   // Register writes.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff      <= FMT_RAW;
         dither_enable_ff     <= 1'b0;
         color_order_ff       <= ORD_RGB;
         global_brightness_ff <= 5'd31;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_PIXEL_FORMAT:      pixel_format_ff      <= csr_chan.data[1:0];
            REG_DITHER_ENABLE:     dither_enable_ff     <= csr_chan.data[0];
            REG_COLOR_ORDER:       color_order_ff       <= csr_chan.data[2:0];
            REG_GLOBAL_BRIGHTNESS: global_brightness_ff <= csr_chan.data[4:0];
            default: begin
            end
         endcase
      end
   end

   // Input handshake: one pixel may wait in the stage register.
   assign req_chan.ready = !stage_valid_ff || rec_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // The first pixel of a frame advances the phase before it is dithered.
   assign phase_in  = (accept && req_chan.first_pixel) ? phase_ff + 2'd1 : phase_ff;
   assign dither_on = dither_enable_ff && (pixel_format_ff != FMT_ONEWIRE_W);
   assign onewire   = (pixel_format_ff == FMT_ONEWIRE) || (pixel_format_ff == FMT_ONEWIRE_W);

   // Lane inputs: red, green, blue, then the white value which is never dithered.
   assign lane_value[0] = req_chan.red;
   assign lane_value[1] = req_chan.green;
   assign lane_value[2] = req_chan.blue;
   assign lane_value[3] = req_chan.extra;
   assign lane_frac[0]  = req_chan.extra[5:4];
   assign lane_frac[1]  = req_chan.extra[3:2];
   assign lane_frac[2]  = req_chan.extra[1:0];
   assign lane_frac[3]  = 2'd0;

   for (genvar g = 0; g < 4; g++) begin : g_lane
      lpse_lane u_lane (
         .value     (lane_value[g]),
         .frac      (lane_frac[g]),
         .dither_on (dither_on && (g < 3)),
         .phase     (phase_in),
         .enc_byte  (lane_byte[g]),
         .enc_word  (lane_word[g])
      );
   end

   // Lane select per output slot; unused order codes fall back to RGB.
   always_comb begin
      unique case (color_order_ff)
         ORD_RBG: begin sel[0] = 2'd0; sel[1] = 2'd2; sel[2] = 2'd1; end
         ORD_GRB: begin sel[0] = 2'd1; sel[1] = 2'd0; sel[2] = 2'd2; end
         ORD_BGR: begin sel[0] = 2'd2; sel[1] = 2'd1; sel[2] = 2'd0; end
         ORD_BRG: begin sel[0] = 2'd2; sel[1] = 2'd0; sel[2] = 2'd1; end
         ORD_GBR: begin sel[0] = 2'd1; sel[1] = 2'd2; sel[2] = 2'd0; end
         default: begin sel[0] = 2'd0; sel[1] = 2'd1; sel[2] = 2'd2; end
      endcase
   end

   // Merge the lanes into one pixel record, data MSB first.
   always_comb begin
      rec_in.clocked   = (pixel_format_ff == FMT_CLOCKED);
      rec_in.first     = req_chan.first_pixel;
      rec_in.last      = req_chan.last_pixel;
      rec_in.head_byte = HEADER_MARK | {3'b000, global_brightness_ff};
      if (onewire) begin
         rec_in.data = {lane_word[sel[0]], lane_word[sel[1]], lane_word[sel[2]],
                        lane_word[3]};
         rec_in.data_len = (pixel_format_ff == FMT_ONEWIRE_W) ? LEN_ONEW_W : LEN_ONEWIRE;
      end else begin
         rec_in.data = {lane_byte[sel[0]], lane_byte[sel[1]], lane_byte[sel[2]],
                        {(DATA_W-24){1'b0}}};
         rec_in.data_len = LEN_BYTES;
      end
   end

   // Stage register between the lanes and the serializer.
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (rec_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         phase_ff       <= 2'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= rec_in;
      end
   end

   lpse_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (stage_valid_ff),
      .rec       (stage_ff),
      .rec_ready (rec_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
